[rtl/core/epdc_pkg.sv]
// Shared types and constants for the Euler path degree check block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package epdc_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned IdxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned LabelW      = 8;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } epdc_mode_e;

  typedef struct packed {
    epdc_mode_e          mode;
    logic [LabelW-1:0]   label_a;
    logic [LabelW-1:0]   label_b;
  } epdc_in_t;

  typedef struct packed {
    logic                path_exists;
    logic [CntW-1:0]     odd_vertices;
    logic                bad_edge_seen;
  } epdc_out_t;

endpackage

[rtl/core/epdc_adj_mem.sv]
// Adjacency row memory: one write and one registered read per cycle.
// Per-row valid bits make a cleared or never-written row read as zero. Uses epdc_pkg.
`timescale 1ns / 1ps

module epdc_adj_mem
  import epdc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  logic                   we_i,
  input  logic [IdxW-1:0]        waddr_i,
  input  logic [MaxVertices-1:0] wdata_i,
  input  logic [IdxW-1:0]        raddr_i,
  output logic [MaxVertices-1:0] rdata_o
);

  logic [MaxVertices-1:0] mem_q [MaxVertices];
  logic [MaxVertices-1:0] valid_q;
  logic [MaxVertices-1:0] rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[raddr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

[rtl/core/euler_path_degree_check_core.sv]
// Top level of the Euler path degree check: sequencer, label table, counters.
// Depends on epdc_pkg and epdc_adj_mem.
`timescale 1ns / 1ps
//
//  Channel   Signals                          Direction  Transfer
//  -------   -------------------------------  ---------  ------------------------
//  command   start, busy, cmd_i               in         start && !busy
//  result    done_o, result_o                 out        one cycle at done_o
//  config    cfg_we_i, cfg_wdata_i            in         cfg_we_i, no wait
//
//  Label load and clear are done without leaving idle, so busy stays low.
//  Edge insert: scan the loaded labels one table entry at a time with one shared
//  comparator pair, then two read-modify-write passes on the row memory (row x,
//  then row y); a missing endpoint sets the bad flag and skips both passes.
//  Query: each examined row gets a registered memory read, then parity and
//  count; min(vertex_count, 32) rows are examined before done_o.
//  Reset clears control state and the row valid bits at once; no clearing pass.
//  The receiver cannot stall: done_o marks the result for exactly one cycle.

module euler_path_degree_check_core
  import epdc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  epdc_in_t        cmd_i,
  output logic            done_o,
  output epdc_out_t       result_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_RD_X  = 8'b0000_0100,
    ST_WR_X  = 8'b0000_1000,
    ST_RD_Y  = 8'b0001_0000,
    ST_WR_Y  = 8'b0010_0000,
    ST_Q_RD  = 8'b0100_0000,
    ST_Q_ACC = 8'b1000_0000
  } epdc_state_e;

  epdc_state_e state_q, state_d;

  logic [CntW-1:0]        vcount_q;
  logic [CntW-1:0]        loaded_q, loaded_d;
  logic                   bad_q, bad_d;
  logic [CntW-1:0]        cnt_q, cnt_d;      // scan index or row index
  logic [CntW-1:0]        n_q, n_d;          // rows examined by the query
  logic [MaxVertices-1:0] mask_q, mask_d;
  logic [CntW-1:0]        odd_q, odd_d;
  logic [LabelW-1:0]      la_q, lb_q;
  logic                   fa_q, fa_d, fb_q, fb_d;
  logic [IdxW-1:0]        x_q, x_d, y_q, y_d;
  logic                   done_q, done_d;
  epdc_out_t              res_q, res_d;

  logic [LabelW-1:0]      label_q [MaxVertices];
  logic [LabelW-1:0]      tbl_rd_q;
  logic                   accept;
  logic                   tbl_we;
  logic [LabelW-1:0]      tbl_entry;

  logic                   mem_clear, mem_we;
  logic [IdxW-1:0]        mem_waddr, mem_raddr;
  logic [MaxVertices-1:0] mem_wdata, mem_rdata;
  logic [CntW-1:0]        n_clip;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign tbl_entry = tbl_rd_q;
  assign n_clip    = (vcount_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vcount_q;

  // Label table: filled in arrival order, never cleared (fill count gates it).
  assign tbl_we = accept && (cmd_i.mode == MODE_LOAD) && (loaded_q != CntW'(MaxVertices));

  // Read ahead at the next scan index so the entry is ready in the scan cycle.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      label_q[loaded_q[IdxW-1:0]] <= cmd_i.label_a;
    end
    tbl_rd_q <= label_q[cnt_d[IdxW-1:0]];
  end

  epdc_adj_mem u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mem_clear),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    loaded_d  = loaded_q;
    bad_d     = bad_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    mask_d    = mask_q;
    odd_d     = odd_q;
    fa_d      = fa_q;
    fb_d      = fb_q;
    x_d       = x_q;
    y_d       = y_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_clear = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = x_q;
    mem_wdata = mem_rdata | (MaxVertices'(1) << y_q);
    mem_raddr = x_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i.mode)
            MODE_LOAD: begin
              if (tbl_we) begin
                loaded_d = loaded_q + CntW'(1);
              end
            end
            MODE_EDGE: begin
              cnt_d   = '0;
              fa_d    = 1'b0;
              fb_d    = 1'b0;
              state_d = ST_SCAN;
            end
            MODE_QUERY: begin
              cnt_d   = '0;
              odd_d   = '0;
              n_d     = n_clip;
              // Keep only the first n columns of each row.
              mask_d  = n_clip[IdxW] ? '1
                        : ((MaxVertices'(1) << n_clip[IdxW-1:0]) - MaxVertices'(1));
              state_d = ST_Q_RD;
            end
            MODE_CLEAR: begin
              loaded_d  = '0;
              bad_d     = 1'b0;
              mem_clear = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (cnt_q == loaded_q) begin
          if (fa_q && fb_q) begin
            state_d = ST_RD_X;
          end else begin
            bad_d   = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          // Later matches overwrite earlier ones: the last loaded entry wins.
          if (tbl_entry == la_q) begin
            fa_d = 1'b1;
            x_d  = cnt_q[IdxW-1:0];
          end
          if (tbl_entry == lb_q) begin
            fb_d = 1'b1;
            y_d  = cnt_q[IdxW-1:0];
          end
          cnt_d = cnt_q + CntW'(1);
        end
      end

      ST_RD_X: begin
        mem_raddr = x_q;
        state_d   = ST_WR_X;
      end

      ST_WR_X: begin
        mem_we    = 1'b1;
        mem_waddr = x_q;
        mem_wdata = mem_rdata | (MaxVertices'(1) << y_q);
        state_d   = ST_RD_Y;
      end

      ST_RD_Y: begin
        mem_raddr = y_q;
        state_d   = ST_WR_Y;
      end

      ST_WR_Y: begin
        mem_we    = 1'b1;
        mem_waddr = y_q;
        mem_wdata = mem_rdata | (MaxVertices'(1) << x_q);
        state_d   = ST_IDLE;
      end

      ST_Q_RD: begin
        if (cnt_q == n_q) begin
          done_d              = 1'b1;
          res_d.path_exists   = (odd_q == CntW'(0)) || (odd_q == CntW'(2));
          res_d.odd_vertices  = odd_q;
          res_d.bad_edge_seen = bad_q;
          state_d             = ST_IDLE;
        end else begin
          mem_raddr = cnt_q[IdxW-1:0];
          state_d   = ST_Q_ACC;
        end
      end

      ST_Q_ACC: begin
        odd_d   = odd_q + CntW'(^(mem_rdata & mask_q));
        cnt_d   = cnt_q + CntW'(1);
        state_d = ST_Q_RD;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      vcount_q <= '0;
      loaded_q <= '0;
      bad_q    <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      bad_q    <= bad_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    mask_q <= mask_d;
    odd_q  <= odd_d;
    fa_q   <= fa_d;
    fb_q   <= fb_d;
    x_q    <= x_d;
    y_q    <= y_d;
    res_q  <= res_d;
    if (accept) begin
      la_q <= cmd_i.label_a;
      lb_q <= cmd_i.label_b;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[rtl/core/epdc_checker.sv]
// Port-level checker for euler_path_degree_check_core, bound to the top level.
// Depends on epdc_pkg.
`timescale 1ns / 1ps

module epdc_checker
  import epdc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input epdc_in_t  cmd_i,
  input logic      done_o,
  input epdc_out_t result_o
);

  // A result only ends a busy query.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result without a preceding busy phase");

  // Result strobes never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // The answer follows from the reported odd-vertex count.
  a_answer_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.path_exists ==
                ((result_o.odd_vertices == CntW'(0)) ||
                 (result_o.odd_vertices == CntW'(2)))))
    else $error("path_exists disagrees with odd_vertices");

  // At most every vertex can be odd.
  a_odd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.odd_vertices <= CntW'(MaxVertices)))
    else $error("odd_vertices beyond vertex capacity");

  // An accepted query occupies the block.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.mode == MODE_QUERY)) |=> busy)
    else $error("query accepted without going busy");

endmodule

bind euler_path_degree_check_core epdc_checker u_epdc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);

[test/euler_path_degree_check_core_test.sv]
// Self-checking bench for euler_path_degree_check_core: queued commands, a graph predictor,
// and an in-order check of every query answer. Depends on epdc_pkg and the core RTL.
`timescale 1ns / 1ps

module euler_path_degree_check_core_test;
  import epdc_pkg::*;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned SettleCycles = 100;   // exceeds the longest query walk
  localparam int unsigned StallLimit   = 2000;  // cycles with neither an item nor a result
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned RandomPhases = 12;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  epdc_in_t        cmd_i       = '0;
  logic            done_o;
  epdc_out_t       result_o;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;

  euler_path_degree_check_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  // Commands waiting to be offered, and the query answers still owed by the block.
  epdc_in_t    cmd_pending[$];
  epdc_out_t   answer_due[$];

  // Predicted graph state, updated at each accepted item.
  logic [MaxVertices-1:0] adj_model   [MaxVertices];
  logic [LabelW-1:0]      label_model [MaxVertices];
  int unsigned            fill_model  = 0;
  logic                   bad_model   = 1'b0;
  logic [CntW-1:0]        vcount_model = '0;

  logic        item_taken_q = 1'b0;
  int unsigned gap_left     = 0;
  bit          gaps_on      = 1'b1;
  int unsigned stall_cycles = 0;
  int unsigned fail_count   = 0;
  int unsigned queued       = 0;
  int unsigned n_loads = 0, n_edges = 0, n_queries = 0, n_clears = 0;
  int unsigned n_answers = 0, n_yes = 0, n_settings = 0;

  initial begin
    foreach (adj_model[r]) adj_model[r] = '0;
    foreach (label_model[r]) label_model[r] = '0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_cmd(epdc_mode_e mode, logic [LabelW-1:0] la, logic [LabelW-1:0] lb);
    epdc_in_t c;
    c.mode    = mode;
    c.label_a = la;
    c.label_b = lb;
    cmd_pending.push_back(c);
    queued++;
  endtask

  task automatic note_failure(string what, epdc_out_t want, epdc_out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: want path=%0b odd=%0d bad=%0b, got path=%0b odd=%0d bad=%0b",
               $time, what, want.path_exists, want.odd_vertices, want.bad_edge_seen,
               got.path_exists, got.odd_vertices, got.bad_edge_seen);
  endtask

  // Apply one accepted command to the predicted graph; a query queues its answer.
  task automatic apply_to_graph(epdc_in_t c);
    int unsigned            ia, ib, span, odd;
    bit                     fa, fb;
    logic [MaxVertices-1:0] keep;
    epdc_out_t              ans;
    ia = 0;
    ib = 0;
    fa = 1'b0;
    fb = 1'b0;
    case (c.mode)
      MODE_LOAD: begin
        n_loads++;
        // a full table drops further labels
        if (fill_model < MaxVertices) begin
          label_model[fill_model] = c.label_a;
          fill_model++;
        end
      end
      MODE_EDGE: begin
        n_edges++;
        // only loaded entries count; a repeated label resolves to its latest entry
        for (int j = 0; j < fill_model; j++) begin
          if (label_model[j] == c.label_a) begin
            fa = 1'b1;
            ia = j;
          end
          if (label_model[j] == c.label_b) begin
            fb = 1'b1;
            ib = j;
          end
        end
        if (fa && fb) begin
          adj_model[ia][ib] = 1'b1;
          adj_model[ib][ia] = 1'b1;
        end else begin
          bad_model = 1'b1;
        end
      end
      MODE_CLEAR: begin
        n_clears++;
        foreach (adj_model[r]) adj_model[r] = '0;
        fill_model = 0;
        bad_model  = 1'b0;
      end
      default: begin
        n_queries++;
        // rows and columns beyond the vertex count are out of view; cap at the matrix size
        span = (vcount_model > MaxVertices) ? MaxVertices : vcount_model;
        keep = {MaxVertices{1'b1}} >> (MaxVertices - span);
        odd  = 0;
        for (int r = 0; r < span; r++)
          if ($countones(adj_model[r] & keep) % 2 != 0) odd++;
        ans.path_exists   = (odd == 0 || odd == 2);
        ans.odd_vertices  = CntW'(odd);
        ans.bad_edge_seen = bad_model;
        answer_due.push_back(ans);
      end
    endcase
  endtask

  task automatic check_answer(epdc_out_t got);
    epdc_out_t want;
    n_answers++;
    if (answer_due.size() == 0) begin
      note_failure("result with no query pending", '0, got);
    end else begin
      want = answer_due.pop_front();
      if (want.path_exists) n_yes++;
      if (got.path_exists !== want.path_exists || got.odd_vertices !== want.odd_vertices ||
          got.bad_edge_seen !== want.bad_edge_seen)
        note_failure("answer mismatch", want, got);
    end
  endtask

  // Hold until nothing is queued or owed, then let any edge insert still running finish and settle.
  task automatic wait_drained();
    while (cmd_pending.size() != 0 || start || answer_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Monitor: results first, then config, then the item taken at this edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_taken_q <= 1'b0;
    end else begin
      if (done_o !== 1'b0) check_answer(result_o);
      if (cfg_we_i) vcount_model = cfg_wdata_i;
      item_taken_q <= start && !busy;
      if (start && !busy) apply_to_graph(cmd_i);
      if (done_o === 1'b1 || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t no item or result accepted for %0d cycles", $time, StallLimit);
          $display("euler_path_degree_check_core_test NOT OK");
          $finish;
        end
      end
    end
  end

  // Driver: offer the head of the queue, hold it until taken, then idle for a random gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && item_taken_q) void'(cmd_pending.pop_front());
      if (start && !item_taken_q) begin
        // hold the offered item until the block takes it
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
        cmd_i    <= $bits(epdc_in_t)'($urandom);   // noise the block must ignore
      end else if (cmd_pending.size() != 0) begin
        cmd_i    <= cmd_pending[0];
        start    <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    logic [CntW-1:0]   vc_plan[$];
    logic [LabelW-1:0] names[$];
    logic [LabelW-1:0] la, lb;
    int unsigned       k, n_edge, phase_base, roll;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, vertex count still at its reset value of zero: empty query, extreme
    // labels, a repeated label, a self loop, a duplicate edge and an unknown endpoint.
    push_cmd(MODE_QUERY, 8'h00, 8'h00);
    push_cmd(MODE_LOAD, 8'h00, 8'hFF);
    push_cmd(MODE_LOAD, 8'hFF, 8'h00);
    push_cmd(MODE_LOAD, 8'hA5, 8'h5A);
    push_cmd(MODE_LOAD, 8'h5A, 8'hA5);
    push_cmd(MODE_LOAD, 8'h00, 8'h00);
    push_cmd(MODE_EDGE, 8'h00, 8'hFF);
    push_cmd(MODE_EDGE, 8'hA5, 8'hA5);
    push_cmd(MODE_EDGE, 8'hFF, 8'h5A);
    push_cmd(MODE_EDGE, 8'h5A, 8'hFF);
    push_cmd(MODE_EDGE, 8'h3C, 8'hFF);
    push_cmd(MODE_QUERY, 8'hFF, 8'hFF);

    vc_plan = '{6'd63, 6'd32, 6'd0, 6'd1, 6'd2, 6'd33};
    while (vc_plan.size() < RandomPhases) vc_plan.push_back(CntW'($urandom_range(0, 63)));

    for (int p = 0; p < RandomPhases; p++) begin
      // reconfigure only once the block is idle
      wait_drained();
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= vc_plan[p];
      @(negedge clk_i);
      cfg_we_i    <= 1'b0;
      cfg_wdata_i <= CntW'($urandom);
      n_settings++;
      gaps_on = (p % 4) != 3;

      if (p == 0) begin
        // vertex count above the matrix size; the graph from before is queried first
        push_cmd(MODE_QUERY, 8'h00, 8'h00);
        push_cmd(MODE_EDGE, 8'hFF, 8'h3C);
        push_cmd(MODE_EDGE, 8'h5A, 8'hA5);
        push_cmd(MODE_QUERY, 8'h00, 8'h00);
        push_cmd(MODE_CLEAR, 8'hFF, 8'hFF);
        push_cmd(MODE_QUERY, 8'h00, 8'h00);
        push_cmd(MODE_LOAD, 8'h77, 8'h00);
        push_cmd(MODE_EDGE, 8'h77, 8'h77);
        push_cmd(MODE_QUERY, 8'h00, 8'h00);
      end

      // Random graph sessions: clear, load labels, add mostly valid edges, query.
      phase_base = queued;
      while (queued - phase_base < PhaseItems) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      k = $urandom_range(2, 8);
        else if (roll < 92) k = $urandom_range(9, 31);
        else                k = $urandom_range(32, 36);
        if ($urandom_range(0, 9) != 0) begin
          push_cmd(MODE_CLEAR, LabelW'($urandom), LabelW'($urandom));
          names.delete();
        end
        for (int i = 0; i < k; i++) begin
          if (names.size() != 0 && $urandom_range(0, 9) == 0)
            la = names[$urandom_range(0, names.size() - 1)];
          else
            la = LabelW'($urandom);
          names.push_back(la);
          push_cmd(MODE_LOAD, la, LabelW'($urandom));
        end
        n_edge = $urandom_range(1, (k < 12) ? 2 * k : 24);
        for (int e = 0; e < n_edge; e++) begin
          if ($urandom_range(0, 99) < 85) begin
            la = names[$urandom_range(0, names.size() - 1)];
            lb = names[$urandom_range(0, names.size() - 1)];
          end else begin
            la = LabelW'($urandom);
            lb = names[$urandom_range(0, names.size() - 1)];
            if ($urandom_range(0, 1) != 0) begin
              lb = la;
              la = names[$urandom_range(0, names.size() - 1)];
            end
          end
          push_cmd(MODE_EDGE, la, lb);
          if ($urandom_range(0, 5) == 0)
            push_cmd(MODE_QUERY, LabelW'($urandom), LabelW'($urandom));
        end
        push_cmd(MODE_QUERY, LabelW'($urandom), LabelW'($urandom));
        if ($urandom_range(0, 9) == 0)
          push_cmd(epdc_mode_e'($urandom_range(0, 3)), LabelW'($urandom), LabelW'($urandom));
      end
    end

    wait_drained();
    if (answer_due.size() != 0) begin
      fail_count += answer_due.size();
      $display("%0d query answers never arrived", answer_due.size());
    end

    $display("Covered %0d items: %0d label loads, %0d edges, %0d clears, %0d queries",
             queued, n_loads, n_edges, n_clears, n_queries);
    $display("Checked %0d answers (%0d with a path) across %0d vertex count settings",
             n_answers, n_yes, n_settings + 1);
    if (fail_count == 0)
      $display("euler_path_degree_check_core_test OK");
    else
      $display("euler_path_degree_check_core_test NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/core/epdc_pkg.sv
rtl/core/epdc_adj_mem.sv
rtl/core/euler_path_degree_check_core.sv
rtl/core/epdc_checker.sv
test/euler_path_degree_check_core_test.sv
